/* rtl/core/mme_pkg.sv */
`default_nettype none

package mme_pkg;

    // Default operand width of the exponentiator.
    localparam int OPERAND_BITS_DEF = 96;

    // Widths fixed by the word layout on the ports.
    localparam int FULL_BITS = 96;
    localparam int LOW_BITS = 64;
    localparam int HIGH_BITS = 32;
    localparam int WIDTH_BITS = 7;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 64;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS_LOW = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS_HIGH = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RSQUARE_LOW = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RSQUARE_HIGH = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS_WIDTH = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [WIDTH_BITS-1:0] MODULUS_WIDTH_RESET = 7'd96;

    typedef struct packed {
        logic [HIGH_BITS-1:0] base_high;
        logic [LOW_BITS-1:0]  base_low;
        logic [HIGH_BITS-1:0] exponent_high;
        logic [LOW_BITS-1:0]  exponent_low;
    } in_word_t;

    typedef struct packed {
        logic [HIGH_BITS-1:0] power_high;
        logic [LOW_BITS-1:0]  power_low;
    } out_word_t;

endpackage

`default_nettype wire

/* rtl/core/mme_mont.sv */
`default_nettype none

// Radix-2 Montgomery multiplier: one add-and-shift step per cycle, then one
// conditional subtraction of the modulus.
module mme_mont #(
    parameter int OPERAND_BITS = mme_pkg::OPERAND_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [OPERAND_BITS-1:0]         x,
    input  logic [OPERAND_BITS-1:0]         y,
    input  logic [OPERAND_BITS-1:0]         m,
    input  logic [mme_pkg::WIDTH_BITS-1:0]  steps,
    output logic                            done,
    output logic [OPERAND_BITS-1:0]         result
);
    import mme_pkg::*;

    localparam int W = OPERAND_BITS;

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_PREP = 4'b0010,
        M_STEP = 4'b0100,
        M_SUB  = 4'b1000
    } mul_state_t;

    mul_state_t            state_reg;
    mul_state_t            state_next;
    logic [W-1:0]          x_reg;
    logic [W:0]            ym_reg;
    logic [W:0]            t_reg;
    logic [WIDTH_BITS-1:0] cnt_reg;
    logic                  done_reg;
    logic [W-1:0]          result_reg;

    logic                  xi;
    logic                  n;
    logic [W:0]            addend;
    logic [W+1:0]          sum;
    logic [W+1:0]          diff;
    logic [WIDTH_BITS-1:0] cnt_inc;

    assign xi = x_reg[0];
    assign n = t_reg[0] ^ (xi & y[0]);
    assign cnt_inc = cnt_reg + 1'b1;

    always_comb
    begin
        case ({xi, n})
            2'b00:   addend = '0;
            2'b01:   addend = {1'b0, m};
            2'b10:   addend = {1'b0, y};
            default: addend = ym_reg;
        endcase
    end

    assign sum = {1'b0, t_reg} + {1'b0, addend};
    assign diff = {1'b0, t_reg} - {2'b00, m};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_PREP;
                end
            end
            M_PREP:
            begin
                state_next = (steps == '0) ? M_SUB : M_STEP;
            end
            M_STEP:
            begin
                if (cnt_inc == steps)
                begin
                    state_next = M_SUB;
                end
            end
            M_SUB:
            begin
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == M_SUB);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_PREP)
        begin
            ym_reg  <= {1'b0, y} + {1'b0, m};
            t_reg   <= '0;
            cnt_reg <= '0;
            x_reg   <= x;
        end
        else if (state_reg == M_STEP)
        begin
            t_reg   <= sum[W+1:1];
            cnt_reg <= cnt_inc;
            x_reg   <= {1'b0, x_reg[W-1:1]};
        end
        if (state_reg == M_SUB)
        begin
            // A borrow out of the top bit means the sum was below the modulus.
            result_reg <= diff[W+1] ? t_reg[W-1:0] : diff[W-1:0];
        end
    end

    assign done = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* rtl/core/montgomery_modexp_96bit_core.sv */
// Modular exponentiator: power = base ^ exponent mod modulus.
// Input channel (in_valid, in_stall, in_data) carries one word with a base
// and an exponent; the base must be below the modulus. The output channel
// (out_valid, out_stall, out_data) returns one word with the power.
// The modulus, R^2 mod modulus and the Montgomery width n are set through
// the write port (cfg_write, cfg_index, cfg_data); the user must write them
// only while the block is idle, as the block itself does not enforce this.
// The exponent is scanned from its least significant bit. Every product is
// formed by a single shared Montgomery multiplier, one add-and-shift step
// per cycle. With L the bit length of the exponent and k its number of set
// bits, a word needs L + k + 3 products. One word is worked on at a time:
// in_stall is high from acceptance until the result has been moved to the
// output register, and the next word can be taken once the block is idle
// again. A result waiting in the output register does not block the next
// input word; if the receiver is still stalling when a new result is ready,
// the block holds it internally, with in_stall high, until the output
// register frees. Reset clears the sequencer and the output valid, and
// loads modulus 1, R^2 = 0 and n = 96.
`default_nettype none

module montgomery_modexp_96bit_core #(
    parameter int OPERAND_BITS = mme_pkg::OPERAND_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  mme_pkg::in_word_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output mme_pkg::out_word_t                 out_data,
    input  logic                               cfg_write,
    input  logic [mme_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mme_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import mme_pkg::*;

    localparam int W = OPERAND_BITS;

    // The sequencer walks through the products of one exponentiation.
    typedef enum logic [7:0] {
        S_IDLE       = 8'b00000001,
        S_ENTER_ONE  = 8'b00000010,
        S_ENTER_BASE = 8'b00000100,
        S_CHECK      = 8'b00001000,
        S_MUL        = 8'b00010000,
        S_SQR        = 8'b00100000,
        S_EXIT       = 8'b01000000,
        S_DONE       = 8'b10000000
    } seq_state_t;

    seq_state_t            state_reg;
    seq_state_t            state_next;
    logic                  start_reg;
    logic                  start_next;

    // Configuration registers.
    logic [W-1:0]          modulus_reg;
    logic [W-1:0]          modulus_next;
    logic [W-1:0]          rsquare_reg;
    logic [W-1:0]          rsquare_next;
    logic [WIDTH_BITS-1:0] width_reg;
    logic [WIDTH_BITS-1:0] width_next;
    logic [FULL_BITS-1:0]  modulus_full;
    logic [FULL_BITS-1:0]  rsquare_full;

    // Working operands.
    logic [W-1:0]          base_reg;
    logic [W-1:0]          exp_reg;
    logic [W-1:0]          acc_reg;
    logic [W-1:0]          sq_reg;
    logic [FULL_BITS-1:0]  base_in;
    logic [FULL_BITS-1:0]  exp_in;
    logic [FULL_BITS-1:0]  power_full;

    logic                  out_valid_reg;
    out_word_t             out_data_reg;

    logic [W-1:0]          mul_x;
    logic [W-1:0]          mul_y;
    logic                  mul_done;
    logic [W-1:0]          mul_result;
    logic                  accept;
    logic                  out_free;

    assign in_stall = (state_reg != S_IDLE);
    assign accept = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Register writes go through the full 96-bit view, so that the halves
    // land correctly whatever the operand width.
    assign modulus_full = FULL_BITS'(modulus_reg);
    assign rsquare_full = FULL_BITS'(rsquare_reg);

    always_comb
    begin
        modulus_next = modulus_reg;
        rsquare_next = rsquare_reg;
        width_next = width_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODULUS_LOW:
                begin
                    modulus_next = W'({modulus_full[FULL_BITS-1:LOW_BITS], cfg_data});
                end
                REG_MODULUS_HIGH:
                begin
                    modulus_next = W'({cfg_data[HIGH_BITS-1:0],
                                       modulus_full[LOW_BITS-1:0]});
                end
                REG_RSQUARE_LOW:
                begin
                    rsquare_next = W'({rsquare_full[FULL_BITS-1:LOW_BITS], cfg_data});
                end
                REG_RSQUARE_HIGH:
                begin
                    rsquare_next = W'({cfg_data[HIGH_BITS-1:0],
                                       rsquare_full[LOW_BITS-1:0]});
                end
                REG_MODULUS_WIDTH:
                begin
                    width_next = cfg_data[WIDTH_BITS-1:0];
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= W'(1);
            rsquare_reg <= '0;
            width_reg   <= MODULUS_WIDTH_RESET;
        end
        else
        begin
            modulus_reg <= modulus_next;
            rsquare_reg <= rsquare_next;
            width_reg   <= width_next;
        end
    end

    // Operand selection for the shared multiplier. The operands stay put for
    // the whole product because acc and sq change only when it finishes.
    always_comb
    begin
        unique case (state_reg)
            S_ENTER_ONE:
            begin
                mul_x = W'(1);
                mul_y = rsquare_reg;
            end
            S_ENTER_BASE:
            begin
                mul_x = base_reg;
                mul_y = rsquare_reg;
            end
            S_MUL:
            begin
                mul_x = acc_reg;
                mul_y = sq_reg;
            end
            S_SQR:
            begin
                mul_x = sq_reg;
                mul_y = sq_reg;
            end
            S_EXIT:
            begin
                mul_x = acc_reg;
                mul_y = W'(1);
            end
            default:
            begin
                mul_x = acc_reg;
                mul_y = sq_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_ENTER_ONE;
                end
            end
            S_ENTER_ONE:
            begin
                if (mul_done)
                begin
                    state_next = S_ENTER_BASE;
                end
            end
            S_ENTER_BASE:
            begin
                if (mul_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (exp_reg == '0)
                begin
                    state_next = S_EXIT;
                end
                else if (exp_reg[0])
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_SQR;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                if (mul_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_EXIT:
            begin
                if (mul_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A product is launched on every entry into a multiplying state.
    assign start_next = (state_next != state_reg) &&
                        ((state_next == S_ENTER_ONE) || (state_next == S_ENTER_BASE) ||
                         (state_next == S_MUL) || (state_next == S_SQR) ||
                         (state_next == S_EXIT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign base_in = {in_data.base_high, in_data.base_low};
    assign exp_in = {in_data.exponent_high, in_data.exponent_low};
    assign power_full = FULL_BITS'(acc_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_reg <= base_in[W-1:0];
            exp_reg  <= exp_in[W-1:0];
        end
        if (mul_done)
        begin
            if ((state_reg == S_ENTER_ONE) || (state_reg == S_MUL) ||
                (state_reg == S_EXIT))
            begin
                acc_reg <= mul_result;
            end
            if ((state_reg == S_ENTER_BASE) || (state_reg == S_SQR))
            begin
                sq_reg <= mul_result;
            end
            if (state_reg == S_SQR)
            begin
                exp_reg <= {1'b0, exp_reg[W-1:1]};
            end
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_data_reg.power_low  <= power_full[LOW_BITS-1:0];
            out_data_reg.power_high <= power_full[FULL_BITS-1:LOW_BITS];
        end
    end

    mme_mont #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_mont (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .x      (mul_x),
        .y      (mul_y),
        .m      (modulus_reg),
        .steps  (width_reg),
        .done   (mul_done),
        .result (mul_result)
    );

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

`default_nettype wire

/* rtl/core/mme_checker.sv */
`default_nettype none

module mme_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input mme_pkg::out_word_t  out_data
);
    import mme_pkg::*;

    // A held result keeps its word until it is taken.
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result word changed or vanished while stalled");

    // Once a word is taken the block is busy with it.
    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("input not stalled after a word was accepted");

    // A new result only comes out of a busy block.
    property p_result_from_busy;
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall);
    endproperty
    a_result_from_busy: assert property (p_result_from_busy)
        else $error("result appeared while the block was idle");

    // An accepted word never yields an immediate result.
    property p_no_instant_result;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> ##2 !$rose(out_valid);
    endproperty
    a_no_instant_result: assert property (p_no_instant_result)
        else $error("result appeared too soon after an accepted word");

endmodule

bind montgomery_modexp_96bit_core mme_checker u_mme_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
